// ===== hw/rtl/ppmdr_pkg.sv =====
// ppmdr_pkg: shared types, register map and reset constants for the ppm decode and regenerate block
// depends on nothing; imported by ppmdr_apb, ppmdr_engine and the top level
`default_nettype none

package ppmdr_pkg;

    localparam int unsigned CHANNELS_DEF = 8;
    localparam int unsigned VAL_W        = 16;
    localparam int unsigned ELAPSED_W    = 20;
    localparam int unsigned ADDR_W       = 4;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned CH_FIELD_W   = 3;

    localparam logic [VAL_W-1:0]     SYNC_GAP_MIN_RST = 16'd3000;
    localparam logic [VAL_W-1:0]     PULSE_WIDTH_RST  = 16'd300;
    localparam logic [VAL_W-1:0]     FRAME_LENGTH_RST = 16'd20000;
    localparam logic [VAL_W-1:0]     VAL_MAX          = 16'hFFFF;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX      = 20'hFFFFF;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SYNC_GAP_MIN = 2'd0;
    localparam logic [1:0] REG_PULSE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        PH_GAP        = 2'd0,
        PH_PULSE      = 2'd1,
        PH_SYNC_GAP   = 2'd2,
        PH_SYNC_PULSE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [VAL_W-1:0] sync_gap_min;
        logic [VAL_W-1:0] pulse_width;
        logic [VAL_W-1:0] frame_length;
    } cfg_t;

    // packed so that ppm_out sits in the lowest bit
    typedef struct packed {
        logic                  sync_seen;
        logic [VAL_W-1:0]      capture_width;
        logic [CH_FIELD_W-1:0] capture_channel;
        logic                  capture_valid;
        logic                  frame_start;
        logic                  ppm_out;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppmdr_apb.sv =====
// ppmdr_apb: apb-style configuration registers of the ppm block
// depends on ppmdr_pkg
`default_nettype none

module ppmdr_apb
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppmdr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ppmdr_pkg::DATA_W-1:0]  pwdata,
    output logic      [ppmdr_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    output ppmdr_pkg::cfg_t                    cfg
);
    import ppmdr_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_gap_min <= SYNC_GAP_MIN_RST;
            cfg_reg.pulse_width  <= PULSE_WIDTH_RST;
            cfg_reg.frame_length <= FRAME_LENGTH_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SYNC_GAP_MIN: cfg_reg.sync_gap_min <= pwdata[VAL_W-1:0];
                REG_PULSE_WIDTH:  cfg_reg.pulse_width  <= pwdata[VAL_W-1:0];
                REG_FRAME_LENGTH: cfg_reg.frame_length <= pwdata[VAL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SYNC_GAP_MIN: prdata = DATA_W'(cfg_reg.sync_gap_min);
            REG_PULSE_WIDTH:  prdata = DATA_W'(cfg_reg.pulse_width);
            REG_FRAME_LENGTH: prdata = DATA_W'(cfg_reg.frame_length);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ppmdr_engine.sv =====
// ppmdr_engine: per-tick state of the ppm decoder and frame regenerator, one tick per step
// depends on ppmdr_pkg; instanced by the top level
`default_nettype none

module ppmdr_engine
#(
    parameter int unsigned CHANNELS = ppmdr_pkg::CHANNELS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ppmdr_pkg::cfg_t cfg,
    input  wire logic            step,
    input  wire logic            level,
    output ppmdr_pkg::result_t   res
);
    import ppmdr_pkg::*;

    localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned IDX_W  = $clog2(CHANNELS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHANNELS - 1);
    localparam logic [IDX_W-1:0]  IDX_FULL  = IDX_W'(CHANNELS);

    logic [VAL_W-1:0]     dec_reg [CHANNELS];
    logic [VAL_W-1:0]     snap_reg [CHANNELS];
    logic [VAL_W-1:0]     edge_cnt_reg, edge_cnt_next;
    logic                 prev_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    phase_t               phase_reg, ph1, ph2;
    logic [SLOT_W-1:0]    slot_reg, slot1, slot2;
    logic [VAL_W-1:0]     cnt_reg, cnt_next, cd1, cd2;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next, el_base;

    logic [VAL_W-1:0]     pw;
    logic [VAL_W-1:0]     gap_val;
    logic [ELAPSED_W:0]   el_sum;
    logic [ELAPSED_W:0]   frame_len_ext;
    logic                 start;
    logic [VAL_W-1:0]     t;
    logic                 fall;
    logic                 sync;
    logic                 cap;

    // output side: at most two phase entries per tick, since a pulse is never empty
    always_comb
    begin
        pw            = (cfg.pulse_width == '0) ? VAL_W'(1) : cfg.pulse_width;
        gap_val       = (slot_reg == '0) ? dec_reg[0] : snap_reg[slot_reg];
        el_sum        = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(pw);
        frame_len_ext = (ELAPSED_W + 1)'(cfg.frame_length);
        start         = 1'b0;
        ph1           = phase_reg;
        slot1         = slot_reg;
        cd1           = cnt_reg;
        if (cnt_reg == '0)
        begin
            case (phase_reg)
                PH_GAP:
                begin
                    start = (slot_reg == '0);
                    cd1   = (gap_val > pw) ? gap_val - pw : '0;
                    ph1   = PH_PULSE;
                end
                PH_PULSE:
                begin
                    cd1 = pw;
                    if (slot_reg == LAST_SLOT)
                    begin
                        ph1   = PH_SYNC_GAP;
                        slot1 = '0;
                    end
                    else
                    begin
                        ph1   = PH_GAP;
                        slot1 = slot_reg + SLOT_W'(1);
                    end
                end
                PH_SYNC_GAP:
                begin
                    cd1   = (frame_len_ext > el_sum) ? VAL_W'(frame_len_ext - el_sum) : '0;
                    ph1   = PH_SYNC_PULSE;
                    slot1 = '0;
                end
                default:
                begin
                    cd1   = pw;
                    ph1   = PH_GAP;
                    slot1 = '0;
                end
            endcase
        end

        // empty gap: enter the pulse that follows on the same tick
        ph2   = ph1;
        slot2 = slot1;
        cd2   = cd1;
        if (cd1 == '0)
        begin
            case (ph1)
                PH_PULSE:
                begin
                    cd2 = pw;
                    if (slot1 == LAST_SLOT)
                    begin
                        ph2   = PH_SYNC_GAP;
                        slot2 = '0;
                    end
                    else
                    begin
                        ph2   = PH_GAP;
                        slot2 = slot1 + SLOT_W'(1);
                    end
                end
                PH_SYNC_PULSE:
                begin
                    cd2   = pw;
                    ph2   = PH_GAP;
                    slot2 = '0;
                end
                default: ;
            endcase
        end

        cnt_next     = (cd2 != '0) ? cd2 - VAL_W'(1) : '0;
        el_base      = start ? '0 : elapsed_reg;
        elapsed_next = (el_base == ELAPSED_MAX) ? el_base : el_base + ELAPSED_W'(1);
    end

    // decode side
    always_comb
    begin
        t             = (edge_cnt_reg != VAL_MAX) ? edge_cnt_reg + VAL_W'(1) : VAL_MAX;
        fall          = prev_reg && !level;
        sync          = 1'b0;
        cap           = 1'b0;
        idx_next      = idx_reg;
        edge_cnt_next = t;
        if (fall)
        begin
            edge_cnt_next = '0;
            if (t >= cfg.sync_gap_min)
            begin
                sync     = 1'b1;
                idx_next = '0;
            end
            else if (idx_reg < IDX_FULL)
            begin
                cap      = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    assign res.ppm_out         = ph2[0];
    assign res.frame_start     = start;
    assign res.capture_valid   = cap;
    assign res.capture_channel = cap ? CH_FIELD_W'(idx_reg) : '0;
    assign res.capture_width   = cap ? t : '0;
    assign res.sync_seen       = sync;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                dec_reg[i]  <= '0;
                snap_reg[i] <= '0;
            end
            edge_cnt_reg <= VAL_MAX;
            prev_reg     <= 1'b1;
            idx_reg      <= '0;
            phase_reg    <= PH_GAP;
            slot_reg     <= '0;
            cnt_reg      <= '0;
            elapsed_reg  <= '0;
        end
        else if (step)
        begin
            if (start)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    snap_reg[i] <= dec_reg[i];
                end
            end
            if (cap)
            begin
                dec_reg[idx_reg[SLOT_W-1:0]] <= t;
            end
            edge_cnt_reg <= edge_cnt_next;
            prev_reg     <= level;
            idx_reg      <= idx_next;
            phase_reg    <= ph2;
            slot_reg     <= slot2;
            cnt_reg      <= cnt_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // every tick leaves a phase with time still to run
    a_phase_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> cd2 != '0)
        else $error("phase entered with zero length after two entries");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("send slot out of range");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_FULL)
        else $error("decode index beyond slot count");

    a_start_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        step && start |=> elapsed_reg == ELAPSED_W'(1))
        else $error("frame start did not restart the elapsed count");

    a_cap_sync_excl: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(cap && sync))
        else $error("capture and sync on the same edge");

endmodule

`default_nettype wire

// ===== hw/rtl/ppm_decode_and_regenerate_core.sv =====
// ppm_decode_and_regenerate_core: top level, stream handshake around the ppm engine and apb registers
// depends on ppmdr_pkg, ppmdr_apb, ppmdr_engine
//
//   port group   dir   width  content
//   s_*          in    8      one sampled input tick (ppm_level)
//   m_*          out   24     one result beat per tick
//   p*           cfg   32     sync_gap_min, pulse_width, frame_length at 0x0, 0x4, 0x8
//
// one tick per cycle sustained unless the result side stalls; input register, then result register
// all per-tick work is a single pass through the engine between input and result registers
// a stalled result register holds its beat and the input register fills behind it
// reset: frame starts on the first tick, first falling edge is taken as sync
`default_nettype none

module ppm_decode_and_regenerate_core
#(
    parameter int unsigned CHANNELS = ppmdr_pkg::CHANNELS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [0] ppm_level
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] ppm_out, [1] frame_start, [2] capture_valid, [5:3] capture_channel,
    // [21:6] capture_width, [22] sync_seen
    output logic      [23:0]                   m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppmdr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ppmdr_pkg::DATA_W-1:0]  pwdata,
    output logic      [ppmdr_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);
    import ppmdr_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;
    logic    in_valid_reg;
    logic    level_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    ppmdr_apb u_apb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppmdr_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .level (level_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            level_reg <= s_tdata[0];
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result beat lost or changed");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(level_reg))
        else $error("pending input tick lost");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed tick produced no result beat");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for ppm_decode_and_regenerate_core, one sampled line tick per input beat
// predicts decode and regeneration for every accepted tick and checks each result beat by field
// depends on ppmdr_pkg and the core rtl only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmdr_pkg::*;

    localparam int CH       = CHANNELS_DEF;
    localparam int N_PHASES = 6;

    typedef struct packed {
        logic    level;
        logic    fixed;
        result_t beat;
    } tick_row_t;

    localparam result_t QUIET_BEAT = '0;
    localparam result_t FIRST_BEAT = '{sync_seen: 1'b1, capture_width: 16'd0,
        capture_channel: 3'd0, capture_valid: 1'b0, frame_start: 1'b1, ppm_out: 1'b0};
    localparam result_t CAP0_BEAT  = '{sync_seen: 1'b0, capture_width: 16'd3,
        capture_channel: 3'd0, capture_valid: 1'b1, frame_start: 1'b0, ppm_out: 1'b0};
    localparam result_t CAP1_BEAT  = '{sync_seen: 1'b0, capture_width: 16'd2,
        capture_channel: 3'd1, capture_valid: 1'b1, frame_start: 1'b0, ppm_out: 1'b0};

    // reset values: first edge syncs, then short intervals fill the slots and run on past them
    localparam tick_row_t TICK_TABLE [24] = '{
        '{1'b0, 1'b1, FIRST_BEAT}, '{1'b0, 1'b1, QUIET_BEAT},
        '{1'b1, 1'b1, QUIET_BEAT}, '{1'b0, 1'b1, CAP0_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b1, CAP1_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b0, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b0, 1'b1, QUIET_BEAT},
        '{1'b1, 1'b0, QUIET_BEAT}, '{1'b1, 1'b0, QUIET_BEAT}
    };

    localparam cfg_t PHASE_CFG [N_PHASES] = '{
        '{16'd14, 16'd3, 16'd60},
        '{16'd1, 16'd0, 16'd0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'd12, 16'd5, 16'd30},
        '{16'd0, 16'd1, 16'hFFFF},
        '{16'd20, 16'd2, 16'd400}
    };
    localparam int PHASE_TICKS [N_PHASES] = '{90, 35, 35, 85, 35, 80};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [0] ppm_level
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // [0] ppm_out, [1] frame_start, [2] capture_valid, [5:3] capture_channel,
    // [21:6] capture_width, [22] sync_seen
    logic [23:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr  = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [15:0]    cfg_sync_min;
    logic [15:0]    cfg_pulse;
    logic [15:0]    cfg_frame_len;
    logic [15:0]    dec_slots [CH];
    logic [15:0]    dec_interval;
    logic           dec_prev;
    logic [3:0]     dec_index;
    logic [15:0]    gen_snapshot [CH];
    phase_t         gen_phase;
    logic [2:0]     gen_slot;
    logic [15:0]    gen_countdown;
    logic [19:0]    gen_elapsed;

    result_t beats_due [$];
    int      mismatches   = 0;
    int      ticks_sent   = 0;
    int      hold_request = 0;
    int      send_calm    = 0;
    int      sink_calm    = 0;

    ppm_decode_and_regenerate_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic result_t regen_decode_tick(input logic level);
        result_t     r;
        int unsigned pw;
        int unsigned t;
        r  = '0;
        pw = (cfg_pulse == 16'd0) ? 1 : cfg_pulse;
        // a zero-length phase is passed through within the same tick
        for (int g = 0; g < 4 && gen_countdown == 16'd0; g++)
        begin
            case (gen_phase)
                PH_GAP:
                begin
                    if (gen_slot == 3'd0)
                    begin
                        gen_snapshot  = dec_slots;
                        gen_elapsed   = '0;
                        r.frame_start = 1'b1;
                    end
                    gen_countdown = (gen_snapshot[gen_slot] > pw) ?
                                    16'(gen_snapshot[gen_slot] - pw) : 16'd0;
                    gen_phase = PH_PULSE;
                end
                PH_PULSE:
                begin
                    gen_countdown = 16'(pw);
                    if (gen_slot + 1 < CH)
                    begin
                        gen_phase = PH_GAP;
                        gen_slot  = gen_slot + 3'd1;
                    end
                    else
                    begin
                        gen_phase = PH_SYNC_GAP;
                        gen_slot  = 3'd0;
                    end
                end
                PH_SYNC_GAP:
                begin
                    gen_countdown = (cfg_frame_len > gen_elapsed + pw) ?
                                    16'(cfg_frame_len - gen_elapsed - pw) : 16'd0;
                    gen_phase = PH_SYNC_PULSE;
                    gen_slot  = 3'd0;
                end
                default:
                begin
                    gen_countdown = 16'(pw);
                    gen_phase     = PH_GAP;
                    gen_slot      = 3'd0;
                end
            endcase
        end
        // line is high while a gap runs, i.e. while a pulse comes next
        r.ppm_out = (gen_phase == PH_PULSE || gen_phase == PH_SYNC_PULSE);
        if (gen_countdown != 16'd0)
            gen_countdown = gen_countdown - 16'd1;
        if (gen_elapsed != ELAPSED_MAX)
            gen_elapsed = gen_elapsed + 20'd1;

        t = (dec_interval != VAL_MAX) ? dec_interval + 1 : VAL_MAX;
        if (dec_prev && !level)
        begin
            if (t >= cfg_sync_min)
            begin
                dec_index   = '0;
                r.sync_seen = 1'b1;
            end
            else if (dec_index < CH)
            begin
                dec_slots[dec_index] = 16'(t);
                r.capture_valid      = 1'b1;
                r.capture_channel    = dec_index[2:0];
                r.capture_width      = 16'(t);
                dec_index            = dec_index + 4'd1;
            end
            dec_interval = '0;
        end
        else
            dec_interval = 16'(t);
        dec_prev = level;
        return r;
    endfunction

    function automatic int unsigned draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_beat(input logic [23:0] data);
        result_t got;
        result_t want;
        got = data[22:0];
        if (beats_due.size() == 0)
        begin
            flag_mismatch("beat with no tick pending", 32'(data), 0);
            return;
        end
        want = beats_due.pop_front();
        if (got.ppm_out !== want.ppm_out)
            flag_mismatch("ppm_out", 32'(got.ppm_out), 32'(want.ppm_out));
        if (got.frame_start !== want.frame_start)
            flag_mismatch("frame_start", 32'(got.frame_start), 32'(want.frame_start));
        if (got.capture_valid !== want.capture_valid)
            flag_mismatch("capture_valid", 32'(got.capture_valid), 32'(want.capture_valid));
        if (got.capture_channel !== want.capture_channel)
            flag_mismatch("capture_channel", 32'(got.capture_channel),
                          32'(want.capture_channel));
        if (got.capture_width !== want.capture_width)
            flag_mismatch("capture_width", 32'(got.capture_width), 32'(want.capture_width));
        if (got.sync_seen !== want.sync_seen)
            flag_mismatch("sync_seen", 32'(got.sync_seen), 32'(want.sync_seen));
        if (data[23] !== 1'b0)
            flag_mismatch("tdata padding", 32'(data[23]), 0);
    endtask

    task automatic send_tick(input logic level, input logic fixed, input result_t fixed_beat);
        int unsigned gap;
        result_t     predicted;
        gap = draw_wait(send_calm);
        if (gap != 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level};
        do @(posedge clk); while (!s_tready);
        predicted = regen_decode_tick(level);
        beats_due.push_back(fixed ? fixed_beat : predicted);
        ticks_sent++;
    endtask

    // low for a tick or few, then high, so the next falling edge lands total ticks later
    task automatic emit_interval(input int unsigned total);
        int unsigned lo;
        lo = $urandom_range(1, (total > 4) ? 3 : total - 1);
        repeat (lo) send_tick(1'b0, 1'b0, QUIET_BEAT);
        repeat (total - lo) send_tick(1'b1, 1'b0, QUIET_BEAT);
    endtask

    task automatic drive_random(input int budget);
        int stop_at;
        int ch_hi;
        int sync_lo;
        int kind;
        int reps;
        stop_at = ticks_sent + budget;
        ch_hi   = (cfg_sync_min >= 3 && cfg_sync_min <= 13) ? cfg_sync_min - 1 : 12;
        sync_lo = (cfg_sync_min < 2) ? 2 : cfg_sync_min;
        while (ticks_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                if (sync_lo <= 40)
                    emit_interval($urandom_range(sync_lo, sync_lo + 4));
                else
                    emit_interval($urandom_range(20, 40));
                reps = $urandom_range(1, CH + 3);
                for (int k = 0; k < reps && ticks_sent < stop_at; k++)
                    emit_interval($urandom_range(2, ch_hi));
            end
            else if (kind == 7)
            begin
                reps = $urandom_range(1, 12);
                for (int k = 0; k < reps && ticks_sent < stop_at; k++)
                    send_tick(1'($urandom_range(0, 1)), 1'b0, QUIET_BEAT);
            end
            else
            begin
                reps = $urandom_range(1, 4);
                for (int k = 0; k < reps && ticks_sent < stop_at; k++)
                    emit_interval($urandom_range(2, 30));
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_SYNC_GAP_MIN: cfg_sync_min  = value;
            REG_PULSE_WIDTH:  cfg_pulse     = value;
            REG_FRAME_LENGTH: cfg_frame_len = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle_idle();
        @(negedge clk) s_tvalid <= 1'b0;
        for (int n = 0; n < 20000 && beats_due.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : beat_sink
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(sink_calm);
            if (hold_request != 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall != 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
                @(negedge clk) m_tready <= 1'b1;
            end
            do @(posedge clk); while (!(m_tvalid && m_tready));
            check_beat(m_tdata);
        end
    end

    initial
    begin : stimulus
        cfg_sync_min  = SYNC_GAP_MIN_RST;
        cfg_pulse     = PULSE_WIDTH_RST;
        cfg_frame_len = FRAME_LENGTH_RST;
        dec_slots     = '{default: '0};
        gen_snapshot  = '{default: '0};
        dec_interval  = VAL_MAX;
        dec_prev      = 1'b1;
        dec_index     = '0;
        gen_phase     = PH_GAP;
        gen_slot      = '0;
        gen_countdown = '0;
        gen_elapsed   = '0;

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        for (int i = 0; i < 24; i++)
            send_tick(TICK_TABLE[i].level, TICK_TABLE[i].fixed, TICK_TABLE[i].beat);

        for (int p = 0; p < N_PHASES; p++)
        begin
            settle_idle();
            write_reg(REG_SYNC_GAP_MIN, PHASE_CFG[p].sync_gap_min);
            write_reg(REG_PULSE_WIDTH, PHASE_CFG[p].pulse_width);
            write_reg(REG_FRAME_LENGTH, PHASE_CFG[p].frame_length);
            // long sink stall so the core backs up onto its input
            if (p == 0)
                hold_request = 150;
            drive_random(PHASE_TICKS[p]);
        end

        settle_idle();
        if (beats_due.size() != 0)
            flag_mismatch("ticks left without a result", 32'(beats_due.size()), 0);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== ppm_decode_and_regenerate_core.f =====
hw/rtl/ppmdr_pkg.sv
hw/rtl/ppmdr_apb.sv
hw/rtl/ppmdr_engine.sv
hw/rtl/ppm_decode_and_regenerate_core.sv
tb/tb.sv
